FILE: hw/rtl/detection_proximity_merge_assert.svh
// Assertion macros used by the controller RTL of the detection merge block.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef DETECTION_PROXIMITY_MERGE_ASSERT_SVH
`define DETECTION_PROXIMITY_MERGE_ASSERT_SVH

`ifndef SYNTHESIS
`define DPM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define DPM_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define DPM_ASSERT(lbl, prop, msg)
`define DPM_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

FILE: hw/rtl/dpm_pkg.sv
package dpm_pkg;

  localparam int MaxDet = 64;
  localparam int AddrW  = $clog2(MaxDet);
  localparam int CntW   = $clog2(MaxDet + 1);
  localparam int CoordW = 16;
  localparam int IdW    = 4;
  localparam int HeadW  = 16;
  localparam int RadW   = 14;
  localparam int R2W    = 2 * RadW;
  localparam int SqW    = 2 * CoordW;
  localparam int SumW   = SqW + 1;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [IdW-1:0]           id;
    logic [HeadW-1:0]         heading;
  } det_entry_t;

  typedef enum logic [1:0] {
    WSEL_IN  = 2'd0,
    WSEL_RD  = 2'd1,
    WSEL_CUR = 2'd2
  } wsel_e;

  typedef enum logic [9:0] {
    ST_LOAD   = 10'b0000000001,
    ST_RD_I   = 10'b0000000010,
    ST_REF    = 10'b0000000100,
    ST_RD_J   = 10'b0000001000,
    ST_SQ     = 10'b0000010000,
    ST_CMP    = 10'b0000100000,
    ST_MOVE   = 10'b0001000000,
    ST_WB     = 10'b0010000000,
    ST_RD_OUT = 10'b0100000000,
    ST_EMIT   = 10'b1000000000
  } state_e;

  typedef struct packed {
    logic             rd_en;
    logic [AddrW-1:0] rd_addr;
    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
    wsel_e            wr_sel;
    logic             ref_load;
    logic             sq_en;
    logic             merge;
    logic             out_load;
    logic             out_marker;
    logic             out_last;
    logic             out_ovf;
  } dp_cmd_t;

  typedef struct packed {
    logic close;
  } dp_status_t;

endpackage

FILE: hw/rtl/dpm_datapath.sv
module dpm_datapath import dpm_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [RadW-1:0]          cfg_wdata_i,
  input  logic signed [CoordW-1:0] pos_x_i,
  input  logic signed [CoordW-1:0] pos_y_i,
  input  logic [IdW-1:0]           object_id_i,
  input  logic signed [HeadW-1:0]  heading_i,
  input  dp_cmd_t                  cmd_i,
  output dp_status_t               status_o,
  output logic                     out_valid_o,
  output logic signed [CoordW-1:0] out_x_o,
  output logic signed [CoordW-1:0] out_y_o,
  output logic [IdW-1:0]           out_id_o,
  output logic signed [HeadW-1:0]  out_heading_o,
  output logic                     overflowed_o,
  output logic                     is_last_o
);

  det_entry_t mem_q [MaxDet];
  det_entry_t rdata_q;
  det_entry_t wdata;
  det_entry_t cur_q;
  det_entry_t out_q;

  logic [R2W-1:0]           r2_q;
  logic [R2W-1:0]           r2_d;
  logic signed [CoordW-1:0] ref_x_q;
  logic signed [CoordW-1:0] ref_y_q;
  logic [SqW-1:0]           sqx_q;
  logic [SqW-1:0]           sqy_q;
  logic                     out_valid_q;
  logic                     ovf_q;
  logic                     last_q;

  logic signed [CoordW:0]   dx;
  logic signed [CoordW:0]   dy;
  logic [CoordW:0]          adx;
  logic [CoordW:0]          ady;
  logic [CoordW-1:0]        ax;
  logic [CoordW-1:0]        ay;
  logic [SumW-1:0]          dist2;
  logic signed [CoordW:0]   sum_x;
  logic signed [CoordW:0]   sum_y;

  always_comb begin
    case (cmd_i.wr_sel)
      WSEL_IN: begin
        wdata.x       = pos_x_i;
        wdata.y       = pos_y_i;
        wdata.id      = object_id_i;
        wdata.heading = heading_i;
      end
      WSEL_RD:  wdata = rdata_q;
      WSEL_CUR: wdata = cur_q;
      default:  wdata = rdata_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[cmd_i.wr_addr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[cmd_i.rd_addr];
    end
  end

  assign r2_d = R2W'(cfg_wdata_i) * R2W'(cfg_wdata_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r2_q <= '0;
    end else if (cfg_we_i) begin
      r2_q <= r2_d;
    end
  end

  // Distance to the reference position that was latched when the pass began.
  assign dx  = {ref_x_q[CoordW-1], ref_x_q} - {rdata_q.x[CoordW-1], rdata_q.x};
  assign dy  = {ref_y_q[CoordW-1], ref_y_q} - {rdata_q.y[CoordW-1], rdata_q.y};
  assign adx = dx[CoordW] ? -dx : dx;
  assign ady = dy[CoordW] ? -dy : dy;
  assign ax  = adx[CoordW-1:0];
  assign ay  = ady[CoordW-1:0];

  assign dist2 = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign status_o.close = dist2 < SumW'(r2_q);

  // The arithmetic right shift of the sum gives the floor of the average.
  assign sum_x = {cur_q.x[CoordW-1], cur_q.x} + {rdata_q.x[CoordW-1], rdata_q.x};
  assign sum_y = {cur_q.y[CoordW-1], cur_q.y} + {rdata_q.y[CoordW-1], rdata_q.y};

  always_ff @(posedge clk_i) begin
    if (cmd_i.ref_load) begin
      ref_x_q <= rdata_q.x;
      ref_y_q <= rdata_q.y;
      cur_q   <= rdata_q;
    end else if (cmd_i.merge) begin
      cur_q.x <= sum_x[CoordW:1];
      cur_q.y <= sum_y[CoordW:1];
    end
    if (cmd_i.sq_en) begin
      sqx_q <= ax * ax;
      sqy_q <= ay * ay;
    end
    if (cmd_i.out_load) begin
      out_q       <= cmd_i.out_marker ? '0 : rdata_q;
      out_valid_q <= !cmd_i.out_marker;
      ovf_q       <= cmd_i.out_ovf;
      last_q      <= cmd_i.out_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_x_o       = out_q.x;
  assign out_y_o       = out_q.y;
  assign out_id_o      = out_q.id;
  assign out_heading_o = out_q.heading;
  assign overflowed_o  = ovf_q;
  assign is_last_o     = last_q;

endmodule

FILE: hw/rtl/dpm_ctrl.sv
`include "detection_proximity_merge_assert.svh"

module dpm_ctrl import dpm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       det_valid_i,
  output logic       det_ready_o,
  input  logic       has_detection_i,
  input  logic       frame_end_i,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output dp_cmd_t    cmd_o,
  input  dp_status_t status_i
);

  state_e           state_q, state_d;
  logic [CntW-1:0]  num_q, num_d;
  logic [CntW-1:0]  i_q, i_d;
  logic [CntW-1:0]  j_q, j_d;
  logic [AddrW-1:0] k_q, k_d;
  logic             drop_q, drop_d;
  logic             res_valid_q, res_valid_d;

  logic             det_fire;
  logic             slot_free;
  logic [CntW-1:0]  last_idx;
  logic             k_is_last;

  assign det_ready_o = (state_q == ST_LOAD);
  assign det_fire    = det_valid_i && det_ready_o;
  assign slot_free   = !res_valid_q || res_ready_i;
  assign last_idx    = num_q - CntW'(1);
  assign k_is_last   = (CntW'(k_q) == last_idx);
  assign res_valid_o = res_valid_q;

  always_comb begin
    state_d     = state_q;
    num_d       = num_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    drop_d      = drop_q;
    res_valid_d = res_valid_q && !res_ready_i;
    cmd_o       = '0;
    cmd_o.wr_sel = WSEL_IN;

    case (state_q)
      ST_LOAD: begin
        if (det_fire) begin
          if (has_detection_i) begin
            if (num_q < CntW'(MaxDet)) begin
              cmd_o.wr_en   = 1'b1;
              cmd_o.wr_addr = num_q[AddrW-1:0];
              num_d         = num_q + CntW'(1);
            end else begin
              drop_d = 1'b1;
            end
          end
          if (frame_end_i) begin
            i_d     = '0;
            state_d = ST_RD_I;
          end
        end
      end
      ST_RD_I: begin
        if (i_q < num_q) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = i_q[AddrW-1:0];
          state_d       = ST_REF;
        end else begin
          k_d     = '0;
          state_d = ST_RD_OUT;
        end
      end
      ST_REF: begin
        cmd_o.ref_load = 1'b1;
        j_d            = i_q + CntW'(1);
        state_d        = ST_RD_J;
      end
      ST_RD_J: begin
        if (j_q < num_q) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = j_q[AddrW-1:0];
          state_d       = ST_SQ;
        end else begin
          state_d = ST_WB;
        end
      end
      ST_SQ: begin
        cmd_o.sq_en = 1'b1;
        state_d     = ST_CMP;
      end
      ST_CMP: begin
        if (status_i.close) begin
          // Fold j into i, then pull the last entry into slot j and test it again.
          cmd_o.merge   = 1'b1;
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = last_idx[AddrW-1:0];
          num_d         = last_idx;
          state_d       = ST_MOVE;
        end else begin
          j_d     = j_q + CntW'(1);
          state_d = ST_RD_J;
        end
      end
      ST_MOVE: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = j_q[AddrW-1:0];
        cmd_o.wr_sel  = WSEL_RD;
        state_d       = ST_RD_J;
      end
      ST_WB: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = i_q[AddrW-1:0];
        cmd_o.wr_sel  = WSEL_CUR;
        i_d           = i_q + CntW'(1);
        state_d       = ST_RD_I;
      end
      ST_RD_OUT: begin
        if (num_q == '0) begin
          if (slot_free) begin
            cmd_o.out_load   = 1'b1;
            cmd_o.out_marker = 1'b1;
            cmd_o.out_last   = 1'b1;
            cmd_o.out_ovf    = drop_q;
            res_valid_d      = 1'b1;
            drop_d           = 1'b0;
            state_d          = ST_LOAD;
          end
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = k_q;
          state_d       = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = k_is_last;
          cmd_o.out_ovf  = drop_q;
          res_valid_d    = 1'b1;
          if (k_is_last) begin
            num_d   = '0;
            drop_d  = 1'b0;
            state_d = ST_LOAD;
          end else begin
            k_d     = k_q + AddrW'(1);
            state_d = ST_RD_OUT;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      num_q       <= '0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      drop_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      num_q       <= num_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      drop_q      <= drop_d;
      res_valid_q <= res_valid_d;
    end
  end

  `DPM_ASSERT(a_num_bound, num_q <= CntW'(MaxDet), "entry count above capacity")
  `DPM_ASSERT(a_pass_bound, (state_q != ST_LOAD) |-> (i_q <= num_q), "pass index past count")
  `DPM_ASSERT(a_move_slot, (state_q == ST_MOVE) |-> (j_q <= num_q && j_q > i_q), "bad move slot")
  `DPM_ASSERT(a_frame_done, (cmd_o.out_load && cmd_o.out_last) |=> (state_q == ST_LOAD && num_q == '0 && !drop_q), "frame state not cleared")
  `DPM_ASSERT_NEVER(a_port_clash, cmd_o.rd_en && cmd_o.wr_en, "read and write in one cycle")

endmodule

FILE: hw/rtl/detection_proximity_merge.sv
// Collects one frame of detections at one request per cycle into a 64-entry
// store, then merges near-duplicates (squared distance strictly below the
// squared merge radius) and returns the survivors in store order, or a single
// marker request for an empty frame. Detections past capacity are dropped and
// reported through overflowed. The merge runs on one store that is never read
// and written in the same cycle: a pass reads its reference entry and writes
// back the merged entry, a comparison reads an entry and squares its offsets,
// a merge moves the last entry into the freed slot, and a result is read before
// it is emitted. The next frame is accepted once the last result is in the
// output register, which lets that result wait while loading resumes.
module detection_proximity_merge import dpm_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [RadW-1:0]          cfg_wdata_i,
  input  logic                     det_valid_i,
  output logic                     det_ready_o,
  input  logic                     has_detection_i,
  input  logic signed [CoordW-1:0] pos_x_i,
  input  logic signed [CoordW-1:0] pos_y_i,
  input  logic [IdW-1:0]           object_id_i,
  input  logic signed [HeadW-1:0]  heading_i,
  input  logic                     frame_end_i,
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output logic                     out_valid_o,
  output logic signed [CoordW-1:0] out_x_o,
  output logic signed [CoordW-1:0] out_y_o,
  output logic [IdW-1:0]           out_id_o,
  output logic signed [HeadW-1:0]  out_heading_o,
  output logic                     overflowed_o,
  output logic                     is_last_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  dpm_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .det_valid_i     (det_valid_i),
    .det_ready_o     (det_ready_o),
    .has_detection_i (has_detection_i),
    .frame_end_i     (frame_end_i),
    .res_valid_o     (res_valid_o),
    .res_ready_i     (res_ready_i),
    .cmd_o           (cmd),
    .status_i        (status)
  );

  dpm_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .object_id_i   (object_id_i),
    .heading_i     (heading_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (out_valid_o),
    .out_x_o       (out_x_o),
    .out_y_o       (out_y_o),
    .out_id_o      (out_id_o),
    .out_heading_o (out_heading_o),
    .overflowed_o  (overflowed_o),
    .is_last_o     (is_last_o)
  );

endmodule
